[rtl/arf_pkg.sv]
// Shared types and constants for the API frame receiver.
package arf_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned LenW  = 16;

	localparam logic [ByteW-1:0] StartByteReset = 8'h7E;
	localparam logic [ByteW-1:0] ChecksumBase   = 8'hFF;

	localparam logic KindPayload  = 1'b0;
	localparam logic KindFrameEnd = 1'b1;

	// One classified word handed from the front end to the back end.
	// num is the payload position for a payload word, the frame length for
	// a frame-end word.
	typedef struct packed {
		logic              kind;
		logic [ByteW-1:0]  data;
		logic [LenW-1:0]   num;
	} arf_entry_t;

endpackage

[rtl/arf_front.sv]
// Front end: header parsing and classification of received words.
module arf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [arf_pkg::ByteW-1:0]    start_byte,
	input  logic                         accept,
	input  logic [arf_pkg::ByteW-1:0]    rx_byte,
	output logic                         push,
	output arf_pkg::arf_entry_t          push_entry
);

	typedef enum logic [1:0] {
		ST_START,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_GATHER
	} state_t;

	state_t                       state_q;
	logic                         start_ok_q;
	logic [arf_pkg::ByteW-1:0]    len_hi_q;
	logic [arf_pkg::LenW-1:0]     plen_q;
	logic [arf_pkg::LenW-1:0]     count_q;
	logic                         in_payload;

	assign in_payload = (count_q < plen_q);

	always_comb begin
		push_entry = '0;
		push       = accept && (state_q == ST_GATHER);
		if (in_payload) begin
			push_entry.kind = arf_pkg::KindPayload;
			push_entry.data = rx_byte;
			push_entry.num  = count_q;
		end else begin
			push_entry.kind = arf_pkg::KindFrameEnd;
			push_entry.data = rx_byte;
			push_entry.num  = plen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_START;
			start_ok_q <= 1'b0;
			len_hi_q   <= '0;
			plen_q     <= '0;
			count_q    <= '0;
		end else if (accept) begin
			unique case (state_q)
				ST_START: begin
					start_ok_q <= (rx_byte == start_byte);
					state_q    <= ST_LEN_HI;
				end
				ST_LEN_HI: begin
					len_hi_q <= rx_byte;
					state_q  <= ST_LEN_LO;
				end
				ST_LEN_LO: begin
					if (start_ok_q) begin
						plen_q  <= {len_hi_q, rx_byte};
						count_q <= '0;
						state_q <= ST_GATHER;
					end else begin
						// bad delimiter: whole group dropped
						state_q <= ST_START;
					end
				end
				ST_GATHER: begin
					if (in_payload) begin
						count_q <= count_q + 1'b1;
					end else begin
						state_q <= ST_START;
					end
				end
				default: begin
					state_q <= ST_START;
				end
			endcase
		end
	end

endmodule

[rtl/arf_queue.sv]
// Two-entry word queue between front end and back end.
module arf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  arf_pkg::arf_entry_t   push_entry,
	input  logic                  pop,
	output arf_pkg::arf_entry_t   head,
	output logic                  empty,
	output logic                  full
);

	arf_pkg::arf_entry_t  mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

[rtl/arf_back.sv]
// Back end: checksum accumulation and result output register.
module arf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  arf_pkg::arf_entry_t         head,
	input  logic                        empty,
	output logic                        pop,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        kind,
	output logic [arf_pkg::ByteW-1:0]   data_byte,
	output logic [arf_pkg::LenW-1:0]    position,
	output logic [arf_pkg::ByteW-1:0]   frame_type,
	output logic [arf_pkg::LenW-1:0]    frame_length,
	output logic                        checksum_ok
);

	logic                         vld_q;
	logic [arf_pkg::ByteW-1:0]    sum_q;
	logic [arf_pkg::ByteW-1:0]    type_q;
	logic                         kind_q;
	logic [arf_pkg::ByteW-1:0]    data_q;
	logic [arf_pkg::LenW-1:0]     pos_q;
	logic [arf_pkg::ByteW-1:0]    ftype_q;
	logic [arf_pkg::LenW-1:0]     flen_q;
	logic                         ok_q;
	logic                         first;

	assign pop   = !empty && (!vld_q || !res_stall);
	assign first = (head.num == '0);

	assign res_valid    = vld_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign position     = pos_q;
	assign frame_type   = ftype_q;
	assign frame_length = flen_q;
	assign checksum_ok  = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			sum_q  <= '0;
			type_q <= '0;
		end else begin
			if (pop) begin
				vld_q <= 1'b1;
				if (head.kind == arf_pkg::KindPayload) begin
					// first payload word restarts sum and type
					sum_q <= first ? head.data : sum_q + head.data;
					if (first) begin
						type_q <= head.data;
					end
				end else begin
					sum_q  <= '0;
					type_q <= '0;
				end
			end else if (!res_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			if (head.kind == arf_pkg::KindPayload) begin
				data_q  <= head.data;
				pos_q   <= head.num;
				ftype_q <= '0;
				flen_q  <= '0;
				ok_q    <= 1'b0;
			end else begin
				data_q  <= '0;
				pos_q   <= '0;
				ftype_q <= type_q;
				flen_q  <= head.num;
				ok_q    <= (head.data == (arf_pkg::ChecksumBase - sum_q));
			end
		end
	end

endmodule

[rtl/api_frame_receiver_top.sv]
// Top level of the API frame receiver: front end, word queue, back end.
// Path: an accepted payload or checksum word is written into the word queue,
// then into the result register; header words give no result.
// Throughput: one word per cycle sustained while res_stall is low, set by the
// two-entry queue between the header parser and the checksum/output stage.
// Reset: arst_n clears parser state, queue and output valid at once;
// start_byte returns to 0x7E.
module api_frame_receiver_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        start_byte_we,
	input  logic [arf_pkg::ByteW-1:0]   start_byte_wdata,
	// receive channel
	input  logic                        rx_valid,
	output logic                        rx_stall,
	input  logic [arf_pkg::ByteW-1:0]   rx_byte,
	// result channel
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        kind,
	output logic [arf_pkg::ByteW-1:0]   data_byte,
	output logic [arf_pkg::LenW-1:0]    position,
	output logic [arf_pkg::ByteW-1:0]   frame_type,
	output logic [arf_pkg::LenW-1:0]    frame_length,
	output logic                        checksum_ok
);

	logic [arf_pkg::ByteW-1:0]  start_byte_q;
	logic                       accept;
	logic                       push;
	arf_pkg::arf_entry_t        push_entry;
	logic                       pop;
	arf_pkg::arf_entry_t        head;
	logic                       empty;
	logic                       full;

	// Delimiter register; the user writes it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= arf_pkg::StartByteReset;
		end else if (start_byte_we) begin
			start_byte_q <= start_byte_wdata;
		end
	end

	// Stall on a full queue only; header words are held too, which costs nothing
	// at the sustained rate since the queue drains every cycle without res_stall.
	assign rx_stall = full;
	assign accept   = rx_valid && !rx_stall;

	// Header parsing and classification of each word.
	arf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_byte (start_byte_q),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouples the parser from output back-pressure.
	arf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	// Running sum, frame type capture and the result register.
	arf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.position     (position),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.checksum_ok  (checksum_ok)
	);

endmodule

[verif/tb_api_frame_receiver_top.sv]
// Self-checking testbench for the API frame receiver: directed and random byte streams.
module tb_api_frame_receiver_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Watchdog in clock cycles. Even with every gap and stall at its longest
	// a run stays well below this.
	localparam int unsigned CycleLimit  = 1_000_000;
	localparam int unsigned RandomWords = 1450;
	localparam int unsigned MaxReported = 10;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1
	} deframe_phase_t;

	// One result word as seen on the output port.
	typedef struct packed {
		logic                              kind;
		logic [arf_pkg::ByteW-1:0]         data_byte;
		logic [arf_pkg::LenW-1:0]          position;
		logic [arf_pkg::ByteW-1:0]         frame_type;
		logic [arf_pkg::LenW-1:0]          frame_length;
		logic                              checksum_ok;
	} rx_word_t;

	logic                              clk;
	logic                              arst_n;
	logic                              start_byte_we;
	logic [arf_pkg::ByteW-1:0]         start_byte_wdata;
	logic                              rx_valid;
	logic                              rx_stall;
	logic [arf_pkg::ByteW-1:0]         rx_byte;
	logic                              res_valid;
	logic                              res_stall;
	logic                              kind;
	logic [arf_pkg::ByteW-1:0]         data_byte;
	logic [arf_pkg::LenW-1:0]          position;
	logic [arf_pkg::ByteW-1:0]         frame_type;
	logic [arf_pkg::LenW-1:0]          frame_length;
	logic                              checksum_ok;

	api_frame_receiver_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start_byte_we    (start_byte_we),
		.start_byte_wdata (start_byte_wdata),
		.rx_valid         (rx_valid),
		.rx_stall         (rx_stall),
		.rx_byte          (rx_byte),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.kind             (kind),
		.data_byte        (data_byte),
		.position         (position),
		.frame_type       (frame_type),
		.frame_length     (frame_length),
		.checksum_ok      (checksum_ok)
	);

	// ------------------------------------------------------------------
	// Deframer predictor state: mirrors the block's parser, updated once
	// per accepted word.
	// ------------------------------------------------------------------
	logic [arf_pkg::ByteW-1:0]  cfg_start;
	deframe_phase_t             pr_phase;
	logic [1:0]                 pr_hdr_pos;
	logic                       pr_start_ok;
	logic [arf_pkg::ByteW-1:0]  pr_len_hi;
	logic [arf_pkg::LenW-1:0]   pr_len;
	logic [arf_pkg::LenW-1:0]   pr_count;
	logic [arf_pkg::ByteW-1:0]  pr_sum;
	logic [arf_pkg::ByteW-1:0]  pr_type;

	rx_word_t          pending_words[$];   // results still owed by the block
	int unsigned       words_sent;
	int unsigned       mismatches;
	bit                no_gaps;            // calm stretch: no idling on either side

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends here.
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Gap length: mostly short, now and then a long one.
	function automatic int unsigned gap_len();
		if ($urandom_range(99) < 85)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Result side back-pressure.
	int unsigned stall_left;
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!no_gaps && $urandom_range(99) < 30) begin
			res_stall  <= 1'b1;
			stall_left <= gap_len();
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Step the predictor with one accepted byte; queue whatever it produces.
	task automatic deframe_byte(input logic [arf_pkg::ByteW-1:0] b);
		rx_word_t                   w;
		logic [arf_pkg::ByteW-1:0]  want;
		w = '0;
		if (pr_phase == PH_PAYLOAD) begin
			if (pr_count < pr_len) begin
				if (pr_count == '0)
					pr_type = b;
				pr_sum      = pr_sum + b;
				w.kind      = arf_pkg::KindPayload;
				w.data_byte = b;
				w.position  = pr_count;
				pr_count    = pr_count + 1'b1;
			end else begin
				// checksum byte closes the frame
				want           = arf_pkg::ChecksumBase - pr_sum;
				w.kind         = arf_pkg::KindFrameEnd;
				w.frame_type   = pr_type;
				w.frame_length = pr_len;
				w.checksum_ok  = (b == want);
				pr_phase       = PH_HEADER;
				pr_hdr_pos     = 2'd0;
			end
			pending_words.push_back(w);
		end else begin
			pr_phase = PH_HEADER;
			case (pr_hdr_pos)
				2'd0: begin
					// start byte compared against the register as it is now
					pr_start_ok = (b == cfg_start);
					pr_hdr_pos  = 2'd1;
				end
				2'd1: begin
					pr_len_hi  = b;
					pr_hdr_pos = 2'd2;
				end
				default: begin
					pr_hdr_pos = 2'd0;
					if (pr_start_ok) begin
						pr_len   = {pr_len_hi, b};
						pr_count = '0;
						pr_sum   = '0;
						pr_type  = '0;
						pr_phase = PH_PAYLOAD;
					end
				end
			endcase
		end
	endtask

	// Send one word on the receive channel, with an optional idle gap first.
	// Returns at the edge where the word was taken.
	task automatic send_byte(input logic [arf_pkg::ByteW-1:0] b);
		int unsigned n;
		n = 0;
		if (!no_gaps && $urandom_range(99) >= 65)
			n = gap_len();
		if (n != 0) begin
			rx_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		deframe_byte(b);
		words_sent++;
	endtask

	// Stop sending, let every owed result out, then keep idling for the parser,
	// since header words leave nothing to wait for.
	task automatic wait_idle();
		rx_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_byte(input logic [arf_pkg::ByteW-1:0] v);
		wait_idle();
		start_byte_we    <= 1'b1;
		start_byte_wdata <= v;
		@(posedge clk);
		cfg_start = v;
		start_byte_we <= 1'b0;
	endtask

	// Well-formed frame with random payload; checksum right or random.
	task automatic send_frame(input logic [arf_pkg::LenW-1:0] len, input bit good_sum);
		logic [arf_pkg::ByteW-1:0] sum;
		logic [arf_pkg::ByteW-1:0] b;
		sum = '0;
		send_byte(cfg_start);
		send_byte(len[arf_pkg::LenW-1:arf_pkg::ByteW]);
		send_byte(len[arf_pkg::ByteW-1:0]);
		for (int unsigned i = 0; i < len; i++) begin
			b   = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		if (good_sum)
			send_byte(arf_pkg::ChecksumBase - sum);
		else
			send_byte(8'($urandom));
	endtask

	// Feed filler until the parser sits at the start of a header group.
	task automatic resync();
		while (pr_phase != PH_HEADER || pr_hdr_pos != 2'd0)
			send_byte(8'($urandom));
	endtask

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin
		rx_word_t got;
		rx_word_t exp_w;
		if (arst_n && res_valid && !res_stall) begin
			got = '{kind, data_byte, position, frame_type, frame_length, checksum_ok};
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReported)
					$display("unexpected result: kind=%0d data=%02h pos=%0d type=%02h len=%0d ok=%0d",
						got.kind, got.data_byte, got.position, got.frame_type,
						got.frame_length, got.checksum_ok);
			end else begin
				exp_w = pending_words.pop_front();
				if (got.kind !== exp_w.kind || got.data_byte !== exp_w.data_byte ||
				    got.position !== exp_w.position ||
				    got.frame_type !== exp_w.frame_type ||
				    got.frame_length !== exp_w.frame_length ||
				    got.checksum_ok !== exp_w.checksum_ok) begin
					mismatches++;
					if (mismatches <= MaxReported) begin
						$display("mismatch: exp kind=%0d data=%02h pos=%0d type=%02h len=%0d ok=%0d",
							exp_w.kind, exp_w.data_byte, exp_w.position,
							exp_w.frame_type, exp_w.frame_length, exp_w.checksum_ok);
						$display("          got kind=%0d data=%02h pos=%0d type=%02h len=%0d ok=%0d",
							got.kind, got.data_byte, got.position, got.frame_type,
							got.frame_length, got.checksum_ok);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Default delimiter after reset, zero-length frame with a good checksum.
	task automatic test_reset_delimiter();
		send_byte(8'h7E);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Payload extremes 0x00 and 0xFF, frame type 0x00, good checksum.
	task automatic test_payload_extremes();
		send_byte(8'h7E);
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	// Delimiter register at both ends; the 0x00 frame has a bad checksum.
	task automatic test_delimiter_extremes();
		write_start_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		write_start_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Delimiter rewritten after the first byte of a group: that group still
	// counts. Then an old-delimiter group is dropped and a new one passes.
	task automatic test_delimiter_change_mid_group();
		write_start_byte(arf_pkg::StartByteReset);
		send_byte(8'h7E);
		write_start_byte(8'h11);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7E);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h11);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h42);
		send_byte(8'hBD);
	endtask

	// Mostly well-formed frames with random content; some dropped groups,
	// noise, truncated frames, bad checksums and delimiter changes.
	task automatic test_random_stream();
		int unsigned                stop_at;
		int unsigned                calm_left;
		int unsigned                r;
		int unsigned                cut;
		logic [arf_pkg::LenW-1:0]   len;
		logic [arf_pkg::ByteW-1:0]  b;
		stop_at   = words_sent + RandomWords;
		calm_left = 0;
		while (words_sent < stop_at) begin
			if (calm_left != 0) begin
				calm_left--;
			end else begin
				no_gaps = 1'b0;
				if ($urandom_range(99) < 5) begin
					no_gaps   = 1'b1;
					calm_left = $urandom_range(15, 5);
				end
			end
			r = $urandom_range(99);
			if ($urandom_range(99) < 75)
				len = 16'($urandom_range(8, 0));
			else if ($urandom_range(99) < 95)
				len = 16'($urandom_range(40, 9));
			else
				len = 16'($urandom_range(300, 256));
			if (r < 65) begin
				send_frame(len, 1'b1);
			end else if (r < 75) begin
				send_frame(len, 1'b0);
			end else if (r < 83) begin
				// dropped group: first byte is anything but the delimiter
				b = 8'($urandom);
				if (b == cfg_start)
					b = b ^ 8'h01;
				send_byte(b);
				send_byte(8'($urandom));
				send_byte(8'($urandom));
			end else if (r < 89) begin
				// truncated frame; resync fills the rest as payload/checksum
				if (len == 0)
					len = 1;
				cut = $urandom_range(len - 1, 0);
				send_byte(cfg_start);
				send_byte(len[arf_pkg::LenW-1:arf_pkg::ByteW]);
				send_byte(len[arf_pkg::ByteW-1:0]);
				repeat (cut) send_byte(8'($urandom));
				resync();
			end else if (r < 94) begin
				// line noise, one or two bytes, the first not a delimiter
				b = 8'($urandom);
				if (b == cfg_start)
					b = b ^ 8'h80;
				send_byte(b);
				if ($urandom_range(1))
					send_byte(8'($urandom));
				resync();
			end else begin
				r = $urandom_range(99);
				if (r < 20)
					write_start_byte(8'h00);
				else if (r < 40)
					write_start_byte(8'hFF);
				else
					write_start_byte(8'($urandom));
			end
		end
		no_gaps = 1'b0;
	endtask

	// Long frame with the length high byte set, sent flat out.
	task automatic test_longest_frame();
		resync();
		no_gaps = 1'b1;
		send_frame(16'h0180, 1'b1);
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n           = 1'b0;
		rx_valid         = 1'b0;
		rx_byte          = '0;
		start_byte_we    = 1'b0;
		start_byte_wdata = '0;
		res_stall        = 1'b0;
		stall_left       = 0;
		no_gaps          = 1'b0;
		words_sent       = 0;
		mismatches       = 0;
		cfg_start        = arf_pkg::StartByteReset;
		pr_phase         = PH_HEADER;
		pr_hdr_pos       = 2'd0;
		pr_start_ok      = 1'b0;
		pr_len_hi        = '0;
		pr_len           = '0;
		pr_count         = '0;
		pr_sum           = '0;
		pr_type          = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_delimiter();
		test_payload_extremes();
		test_delimiter_extremes();
		test_delimiter_change_mid_group();
		test_random_stream();
		test_longest_frame();

		// drain and keep idling so the block can show stray results
		rx_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && pending_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[api_frame_receiver_top.f]
rtl/arf_pkg.sv
rtl/arf_front.sv
rtl/arf_queue.sv
rtl/arf_back.sv
rtl/api_frame_receiver_top.sv
verif/tb_api_frame_receiver_top.sv
